// File: rtl/wmsa_pkg.sv
// Package for the weighted mean / standard deviation accumulator.
// Field widths, snapshot word type, status codes and back-end states.
// No dependencies.
package wmsa_pkg;

	localparam int SAMPLE_W = 16;
	localparam int WEIGHT_W = 16;
	localparam int COUNT_W  = 13;
	localparam int WTOT_W   = 28;
	localparam int WSUM_W   = 45;
	localparam int WSQ_W    = 58;
	localparam int MEAN_W   = 24;
	localparam int SD_W     = 23;
	localparam int STATUS_W = 2;

	localparam int DEF_MAX_ITEMS   = 4096;
	localparam int DEF_QUEUE_DEPTH = 2;

	// divider / root step counts
	localparam int MEAN_STEPS = WSUM_W + 8;    // |sum| * 256
	localparam int MSQ_STEPS  = WSQ_W + 16;    // sum of squares * 65536
	localparam int ROOT_STEPS = MEAN_W;        // root bits
	localparam int DIV_W      = MSQ_STEPS;
	localparam int VAR_W      = 2 * ROOT_STEPS;
	localparam int MSQ_W      = 47;
	localparam int STEP_W     = $clog2(MSQ_STEPS);

	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO_WEIGHT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 2'd2;

	typedef struct packed {
		logic [COUNT_W-1:0]       count;
		logic [WTOT_W-1:0]        weight_total;
		logic signed [WSUM_W-1:0] weighted_sum;
		logic [WSQ_W-1:0]         square_sum;
		logic                     overflowed;
	} snap_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MEAN,
		BK_MSQ,
		BK_SQUARE,
		BK_DIFF,
		BK_ROOT,
		BK_DONE
	} back_state_t;

endpackage

// File: rtl/wmsa_front.sv
// Front end: weight select, product pipeline and running sums.
// Pushes one snapshot word per set into the queue. Depends on wmsa_pkg.
module wmsa_front import wmsa_pkg::*; #(
	parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_wdata,
	input  logic                       push,
	output logic                       full,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [WEIGHT_W-1:0]        weight,
	input  logic                       last,
	input  logic                       q_full,
	output logic                       q_push,
	output snap_t                      q_data
);

	logic use_weights_q;
	logic en;

	logic                       v_s1, last_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic [WEIGHT_W-1:0]        weight_s1;

	logic                v_s2, last_s2;
	logic signed [31:0]  sw_s2;
	logic [31:0]         ss_s2;
	logic [WEIGHT_W-1:0] weight_s2;

	logic                v_s3, last_s3;
	logic signed [31:0]  sw_s3;
	logic [46:0]         ssw_s3;
	logic [WEIGHT_W-1:0] weight_s3;

	logic [COUNT_W-1:0]       count_q, count_n;
	logic [WTOT_W-1:0]        wt_q, wt_n;
	logic signed [WSUM_W-1:0] wsum_q, wsum_n;
	logic [WSQ_W-1:0]         wsq_q, wsq_n;
	logic                     ovf_q, ovf_n;

	logic signed [31:0] s_ext, w_ext;

	assign en   = !(v_s3 && last_s3 && q_full);
	assign full = !en;

	assign s_ext = {{16{sample_s1[SAMPLE_W-1]}}, sample_s1};
	assign w_ext = {16'b0, weight_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_weights_q <= 1'b0;
		end else if (cfg_we) begin
			use_weights_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_s1 <= sample;
			weight_s1 <= use_weights_q ? weight : WEIGHT_W'(1);
			last_s1   <= last;

			sw_s2     <= s_ext * w_ext;
			ss_s2     <= s_ext * s_ext;
			weight_s2 <= weight_s1;
			last_s2   <= last_s1;

			sw_s3     <= sw_s2;
			ssw_s3    <= {16'b0, ss_s2[30:0]} * {31'b0, weight_s2};
			weight_s3 <= weight_s2;
			last_s3   <= last_s2;
		end
	end

	always_comb begin
		if (count_q < COUNT_W'(MAX_ITEMS)) begin
			count_n = count_q + COUNT_W'(1);
			wt_n    = wt_q + {12'b0, weight_s3};
			wsum_n  = wsum_q + {{13{sw_s3[31]}}, sw_s3};
			wsq_n   = wsq_q + {11'b0, ssw_s3};
			ovf_n   = ovf_q;
		end else begin
			count_n = count_q;
			wt_n    = wt_q;
			wsum_n  = wsum_q;
			wsq_n   = wsq_q;
			ovf_n   = 1'b1;
		end
	end

	assign q_push              = en && v_s3 && last_s3;
	assign q_data.count        = count_n;
	assign q_data.weight_total = wt_n;
	assign q_data.weighted_sum = wsum_n;
	assign q_data.square_sum   = wsq_n;
	assign q_data.overflowed   = ovf_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wt_q    <= '0;
			wsum_q  <= '0;
			wsq_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (en && v_s3) begin
			if (last_s3) begin
				count_q <= '0;
				wt_q    <= '0;
				wsum_q  <= '0;
				wsq_q   <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= count_n;
				wt_q    <= wt_n;
				wsum_q  <= wsum_n;
				wsq_q   <= wsq_n;
				ovf_q   <= ovf_n;
			end
		end
	end

endmodule

// File: rtl/wmsa_queue.sv
// Short queue of per-set snapshot words between front and back end.
// Depends on wmsa_pkg.
module wmsa_queue import wmsa_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  snap_t wr_data,
	output logic  q_full,
	output logic  rd_valid,
	input  logic  rd_en,
	output snap_t rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	snap_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  fill_q;
	logic              do_wr, do_rd;

	assign q_full   = (fill_q == CNT_W'(DEPTH));
	assign rd_valid = (fill_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !q_full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/wmsa_back.sv
// Back end: shared restoring divider (mean, mean of squares), square,
// digit-by-digit integer root and the result register. Depends on wmsa_pkg.
module wmsa_back import wmsa_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  snap_t                    q_data,
	output logic                     q_pop,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [MEAN_W-1:0] mean,
	output logic [SD_W-1:0]          std_dev,
	output logic [COUNT_W-1:0]       item_count,
	output logic [STATUS_W-1:0]      status
);

	back_state_t state_q, state_n;

	snap_t                    snap_q;
	logic                     zero_q;
	logic [STEP_W-1:0]        step_q;
	logic [WTOT_W-1:0]        rem_q;
	logic [DIV_W-1:0]         dq_q;
	logic signed [MEAN_W-1:0] mean_q;
	logic [MSQ_W-1:0]         msq_q;
	logic [VAR_W-1:0]         sq_q;
	logic [VAR_W-1:0]         rv_q;
	logic [ROOT_STEPS+1:0]    rrem_q;
	logic [ROOT_STEPS-1:0]    root_q;
	logic                     out_valid_q;
	logic                     out_free;
	logic                     last_step;

	// divider step
	logic [WTOT_W:0]   rem_sh;
	logic              div_ge;
	logic [WTOT_W-1:0] rem_nx;
	logic [DIV_W-1:0]  dq_nx;

	// mean fix-up
	logic                     neg;
	logic [WSUM_W-1:0]        mag;
	logic [MEAN_W-1:0]        qmag, qadj;
	logic signed [MEAN_W-1:0] mean_nx;

	// root step
	logic [ROOT_STEPS+3:0] rsh;
	logic [ROOT_STEPS+1:0] rtrial;
	logic                  rge;

	assign rem_sh = {rem_q, dq_q[DIV_W-1]};
	assign div_ge = (rem_sh >= {1'b0, snap_q.weight_total});
	assign rem_nx = div_ge ? WTOT_W'(rem_sh - {1'b0, snap_q.weight_total})
	                       : WTOT_W'(rem_sh);
	assign dq_nx  = {dq_q[DIV_W-2:0], div_ge};

	assign neg     = q_data.weighted_sum[WSUM_W-1];
	assign mag     = neg ? (~q_data.weighted_sum + WSUM_W'(1)) : q_data.weighted_sum;
	assign qmag    = dq_nx[MEAN_W-1:0];
	assign qadj    = qmag + MEAN_W'(rem_nx != '0);
	assign mean_nx = snap_q.weighted_sum[WSUM_W-1] ? -qadj : qmag;

	assign rsh    = {rrem_q, rv_q[VAR_W-1 -: 2]};
	assign rtrial = {root_q, 2'b01};
	assign rge    = (rsh >= {2'b00, rtrial});

	assign out_free = !out_valid_q || pop;

	always_comb begin
		state_n   = state_q;
		q_pop     = 1'b0;
		last_step = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_n = (q_data.weight_total == '0) ? BK_DONE : BK_MEAN;
				end
			end
			BK_MEAN: begin
				last_step = (step_q == STEP_W'(MEAN_STEPS - 1));
				if (last_step) begin
					state_n = BK_MSQ;
				end
			end
			BK_MSQ: begin
				last_step = (step_q == STEP_W'(MSQ_STEPS - 1));
				if (last_step) begin
					state_n = BK_SQUARE;
				end
			end
			BK_SQUARE: begin
				state_n = BK_DIFF;
			end
			BK_DIFF: begin
				state_n = BK_ROOT;
			end
			BK_ROOT: begin
				last_step = (step_q == STEP_W'(ROOT_STEPS - 1));
				if (last_step) begin
					state_n = BK_DONE;
				end
			end
			BK_DONE: begin
				if (out_free) begin
					state_n = BK_IDLE;
				end
			end
			default: begin
				state_n = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				snap_q <= q_data;
				zero_q <= (q_data.weight_total == '0);
				step_q <= '0;
				rem_q  <= '0;
				dq_q   <= {mag, 8'b0, {(DIV_W - MEAN_STEPS){1'b0}}};
				mean_q <= '0;
				root_q <= '0;
			end
			BK_MEAN: begin
				step_q <= step_q + STEP_W'(1);
				rem_q  <= rem_nx;
				dq_q   <= dq_nx;
				if (last_step) begin
					mean_q <= mean_nx;
					step_q <= '0;
					rem_q  <= '0;
					dq_q   <= {snap_q.square_sum, 16'b0};
				end
			end
			BK_MSQ: begin
				step_q <= step_q + STEP_W'(1);
				rem_q  <= rem_nx;
				dq_q   <= dq_nx;
				if (last_step) begin
					msq_q <= dq_nx[MSQ_W-1:0];
				end
			end
			BK_SQUARE: begin
				sq_q <= VAR_W'(mean_q * mean_q);
			end
			BK_DIFF: begin
				rv_q   <= ({1'b0, msq_q} > sq_q) ? ({1'b0, msq_q} - sq_q) : '0;
				rrem_q <= '0;
				root_q <= '0;
				step_q <= '0;
			end
			BK_ROOT: begin
				rrem_q <= rge ? (ROOT_STEPS + 2)'(rsh - {2'b00, rtrial})
				              : (ROOT_STEPS + 2)'(rsh);
				root_q <= {root_q[ROOT_STEPS-2:0], rge};
				rv_q   <= {rv_q[VAR_W-3:0], 2'b00};
				step_q <= step_q + STEP_W'(1);
			end
			BK_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == BK_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_DONE && out_free) begin
			mean       <= mean_q;
			std_dev    <= root_q[SD_W-1:0];
			item_count <= snap_q.count;
			if (snap_q.overflowed) begin
				status <= ST_OVERFLOW;
			end else if (zero_q) begin
				status <= ST_ZERO_WEIGHT;
			end else begin
				status <= ST_OK;
			end
		end
	end

	assign empty = !out_valid_q;

endmodule

// File: rtl/weighted_mean_stddev_accumulator_top.sv
// Top level of the weighted mean / standard deviation accumulator.
// Instantiates wmsa_front, wmsa_queue and wmsa_back; depends on wmsa_pkg.
//
// Input channel: sample, weight, last, taken when push is high and full is
// low. One word per cycle is accepted; full rises only while a finished set
// waits for room in the snapshot queue.
// Result channel: mean, std_dev, item_count, status are valid while empty
// is low; a word is taken when pop is high. Only words with last set make
// a result.
// Configuration: cfg_we writes cfg_wdata into use_weights; write only while
// the block is idle.
// Flow: the product pipeline registers s1, s2 and s3 feed the running sums;
// per set the back end then runs 53 mean divide steps, 74 mean-of-squares
// divide steps, square, difference, 24 root steps and the output load. A set
// with zero total weight skips the arithmetic. The shared one-bit-a-cycle
// divider and root unit take a new set only after the last one is done,
// with the queue absorbing short bursts.
// Reset (arst_n low) clears the sums, the queue, use_weights and the
// result valid flag. When the receiver stalls, the result holds, the back
// end finishes its set and waits, then the queue fills and full rises.
module weighted_mean_stddev_accumulator_top import wmsa_pkg::*; #(
	parameter int MAX_ITEMS   = DEF_MAX_ITEMS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_wdata,
	input  logic                       push,
	output logic                       full,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [WEIGHT_W-1:0]        weight,
	input  logic                       last,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [MEAN_W-1:0]   mean,
	output logic [SD_W-1:0]            std_dev,
	output logic [COUNT_W-1:0]         item_count,
	output logic [STATUS_W-1:0]        status
);

	logic  q_full, q_push, q_valid, q_pop;
	snap_t q_wdata, q_rdata;

	wmsa_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.weight    (weight),
		.last      (last),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	wmsa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_data  (q_wdata),
		.q_full   (q_full),
		.rd_valid (q_valid),
		.rd_en    (q_pop),
		.rd_data  (q_rdata)
	);

	wmsa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_data     (q_rdata),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.mean       (mean),
		.std_dev    (std_dev),
		.item_count (item_count),
		.status     (status)
	);

endmodule

// File: rtl/wmsa_checker.sv
// Port-level checks for the weighted mean / standard deviation accumulator.
// Depends on wmsa_pkg; bound to weighted_mean_stddev_accumulator_top.
module wmsa_checker import wmsa_pkg::*; #(
	parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       empty,
	input logic signed [MEAN_W-1:0]   mean,
	input logic [SD_W-1:0]            std_dev,
	input logic [COUNT_W-1:0]         item_count,
	input logic [STATUS_W-1:0]        status
);

	a_reset_empty: assert property (@(posedge clk) (!arst_n ##1 !arst_n) |-> empty)
		else $error("result word present during reset");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status == ST_OK || status == ST_ZERO_WEIGHT || status == ST_OVERFLOW))
		else $error("bad status code");

	a_zero_weight: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_ZERO_WEIGHT) |-> (mean == '0 && std_dev == '0))
		else $error("zero-weight set with nonzero statistics");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (item_count != '0 && item_count <= COUNT_W'(MAX_ITEMS)))
		else $error("item count out of range");

	a_overflow_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_OVERFLOW) |-> item_count == COUNT_W'(MAX_ITEMS))
		else $error("overflow status without full count");

endmodule

bind weighted_mean_stddev_accumulator_top wmsa_checker #(.MAX_ITEMS(MAX_ITEMS)) u_wmsa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.mean       (mean),
	.std_dev    (std_dev),
	.item_count (item_count),
	.status     (status)
);
